// ===== design/assert_macros.svh =====
// assertion macros used by the checker file
// no dependencies
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, reset masks the check
`define ASN_ASSERT_IMPL(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication, reset masks the check
`define ASN_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

// ===== design/ans_pkg.sv =====
// shared types and constants of the note segmenter
// no dependencies
package ans_pkg;

    localparam int ANS_HOP_SAMPLES = 512;
    localparam int ANS_LOG_XW      = 56;
    localparam int ANS_LOG_RW      = 22;
    localparam int ANS_DIV_DW      = 57;
    localparam int ANS_DIV_VW      = 40;

    localparam logic [16:0] ANS_MIN_WEIGHT = 17'd3277;
    localparam logic [16:0] ANS_FULL_CONF  = 17'd65536;
    localparam logic [55:0] ANS_REF_PITCH  = 56'd7040;

    typedef enum logic [2:0] {
        REG_SILENCE_LEVEL,
        REG_PITCH_MIN,
        REG_PITCH_MAX,
        REG_MIN_CONFIDENCE,
        REG_MIN_NOTE_SAMPLES,
        REG_ONSET_COMP,
        REG_MIN_SPLIT,
        REG_ONSET_SETTLE
    } ans_reg_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PREP,
        ST_EVAL,
        ST_LOG_GO,
        ST_LOG_WAIT,
        ST_JCALC,
        ST_DECIDE,
        ST_FLUSH,
        ST_DIV_GO,
        ST_DIV_WAIT,
        ST_MIDI,
        ST_OUT,
        ST_POST
    } ans_state_t;

    typedef struct packed {
        logic                  start;
        logic [ANS_LOG_XW-1:0] operand;
    } ans_log_req_t;

    typedef struct packed {
        logic                  start;
        logic [ANS_DIV_DW-1:0] dividend;
        logic [ANS_DIV_VW-1:0] divisor;
    } ans_div_req_t;

endpackage

// ===== design/ans_if.sv =====
// item channels of the note segmenter: frames in, notes out
// no dependencies
interface ans_frame_if;
    logic        valid;
    logic        ready;
    logic        onset_flag;
    logic [31:0] onset_sample;
    logic [15:0] level_db;
    logic [17:0] pitch_hz;
    logic [16:0] pitch_confidence;
    logic        end_of_stream;
    logic [31:0] final_sample;

    modport source (
        output valid, onset_flag, onset_sample, level_db, pitch_hz,
               pitch_confidence, end_of_stream, final_sample,
        input  ready
    );
    modport sink (
        input  valid, onset_flag, onset_sample, level_db, pitch_hz,
               pitch_confidence, end_of_stream, final_sample,
        output ready
    );
endinterface

interface ans_note_if;
    logic        valid;
    logic        ready;
    logic [31:0] start_sample;
    logic [31:0] end_sample;
    logic [17:0] mean_pitch;
    logic [7:0]  midi_note;
    logic [16:0] mean_confidence;

    modport source (
        output valid, start_sample, end_sample, mean_pitch, midi_note,
               mean_confidence,
        input  ready
    );
    modport sink (
        input  valid, start_sample, end_sample, mean_pitch, midi_note,
               mean_confidence,
        output ready
    );
endinterface

// ===== design/ans_log2.sv =====
// iterative log2 unit, q16 result, one squaring per cycle
// depends on ans_pkg
module ans_log2 (
    input  logic                          clk,
    input  logic                          rst_n,
    input  ans_pkg::ans_log_req_t         req,
    output logic                          done,
    output logic [ans_pkg::ANS_LOG_RW-1:0] result
);
    import ans_pkg::*;

    logic                  busy_reg, busy_next;
    logic                  sq_reg, sq_next;
    logic                  done_reg, done_next;
    logic [ANS_LOG_XW-1:0] x_reg, x_next;
    logic [5:0]            p_reg, p_next;
    logic [30:0]           m_reg, m_next;
    logic [ANS_LOG_RW-1:0] r_reg, r_next;
    logic [3:0]            i_reg, i_next;
    logic [61:0]           sqm;
    logic [31:0]           t;

    assign sqm = 62'(m_reg) * 62'(m_reg);
    assign t   = sqm[61:30];

    always_comb
    begin
        busy_next = busy_reg;
        sq_next   = sq_reg;
        done_next = 1'b0;
        x_next    = x_reg;
        p_next    = p_reg;
        m_next    = m_reg;
        r_next    = r_reg;
        i_next    = i_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            sq_next   = 1'b0;
            x_next    = req.operand;
            p_next    = 6'(ANS_LOG_XW - 1);
            r_next    = '0;
        end
        else if (busy_reg && !sq_reg)
        begin
            // leading-one search, a byte at a time then a bit
            if (x_reg[ANS_LOG_XW-1] || p_reg == 6'd0)
            begin
                sq_next = 1'b1;
                m_next  = x_reg[ANS_LOG_XW-1 -: 31];
                i_next  = 4'd15;
                r_next  = {p_reg, 16'd0};
            end
            else if (x_reg[ANS_LOG_XW-1 -: 8] == 8'd0 && p_reg >= 6'd8)
            begin
                x_next = x_reg << 8;
                p_next = p_reg - 6'd8;
            end
            else
            begin
                x_next = x_reg << 1;
                p_next = p_reg - 6'd1;
            end
        end
        else if (busy_reg)
        begin
            if (t[31])
            begin
                m_next = t[31:1];
                r_next = r_reg | (ANS_LOG_RW'(1) << i_reg);
            end
            else
            begin
                m_next = t[30:0];
            end
            if (i_reg == 4'd0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                i_next = i_reg - 4'd1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            sq_reg   <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            sq_reg   <= sq_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        x_reg <= x_next;
        p_reg <= p_next;
        m_reg <= m_next;
        r_reg <= r_next;
        i_reg <= i_next;
    end

    assign done   = done_reg;
    assign result = r_reg;
endmodule

// ===== design/ans_div.sv =====
// restoring divider, one quotient bit per cycle
// depends on ans_pkg
module ans_div (
    input  logic                           clk,
    input  logic                           rst_n,
    input  ans_pkg::ans_div_req_t          req,
    output logic                           done,
    output logic [ans_pkg::ANS_DIV_DW-1:0] quotient
);
    import ans_pkg::*;

    localparam int CW = $clog2(ANS_DIV_DW);

    logic                  busy_reg, busy_next;
    logic                  done_reg, done_next;
    logic [CW-1:0]         cnt_reg, cnt_next;
    logic [ANS_DIV_VW-1:0] rem_reg, rem_next;
    logic [ANS_DIV_VW-1:0] dvs_reg, dvs_next;
    logic [ANS_DIV_DW-1:0] quo_reg, quo_next;
    logic [ANS_DIV_VW:0]   trial;
    logic                  fits;

    assign trial = {rem_reg, quo_reg[ANS_DIV_DW-1]};
    assign fits  = trial >= {1'b0, dvs_reg};

    always_comb
    begin
        busy_next = busy_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        rem_next  = rem_reg;
        dvs_next  = dvs_reg;
        quo_next  = quo_reg;
        if (req.start)
        begin
            busy_next = 1'b1;
            cnt_next  = CW'(ANS_DIV_DW - 1);
            rem_next  = '0;
            dvs_next  = req.divisor;
            quo_next  = req.dividend;
        end
        else if (busy_reg)
        begin
            if (fits)
            begin
                rem_next = ANS_DIV_VW'(trial - {1'b0, dvs_reg});
            end
            else
            begin
                rem_next = trial[ANS_DIV_VW-1:0];
            end
            quo_next = {quo_reg[ANS_DIV_DW-2:0], fits};
            if (cnt_reg == '0)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
            else
            begin
                cnt_next = cnt_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cnt_reg <= cnt_next;
        rem_reg <= rem_next;
        dvs_reg <= dvs_next;
        quo_reg <= quo_next;
    end

    assign done     = done_reg;
    assign quotient = quo_reg;
endmodule

// ===== design/audio_note_segmenter.sv =====
// a frame with no note arithmetic passes the prep and eval states before ready returns
// a confident pitched frame runs three log2 passes
// a note flush adds one division, or two divisions and three log2 passes for a pitched note;
// a split after the pitch check runs the log2 passes and then the flush; a waiting note item stalls it
// one frame at a time: no new frame is taken until the last one, with its log2 and divider work, is through
// reset (rst_n, async, active low) clears note state, counters and the output valid flag;
// configuration registers return to defaults; no clearing pass is needed
module audio_note_segmenter #(
    parameter int HOP_SAMPLES = ans_pkg::ANS_HOP_SAMPLES
) (
    input  logic        clk,
    input  logic        rst_n,
    ans_frame_if.sink   frame,
    ans_note_if.source  note,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [4:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import ans_pkg::*;

    // configuration registers
    logic signed [15:0] silence_level_reg;
    logic [17:0]        pitch_min_reg;
    logic [17:0]        pitch_max_reg;
    logic [16:0]        min_conf_reg;
    logic [19:0]        min_note_reg;
    logic [15:0]        onset_comp_reg;
    logic [7:0]         min_split_reg;
    logic [15:0]        settle_reg;
    logic               cfg_wr;
    ans_reg_t           cfg_sel;

    assign pready  = 1'b1;
    assign cfg_wr  = psel && penable && pwrite;
    assign cfg_sel = ans_reg_t'(paddr[4:2]);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            silence_level_reg <= -16'sd15360;
            pitch_min_reg     <= 18'd640;
            pitch_max_reg     <= 18'd32000;
            min_conf_reg      <= 17'd32768;
            min_note_reg      <= 20'd2205;
            onset_comp_reg    <= 16'd0;
            min_split_reg     <= 8'd2;
            settle_reg        <= 16'd1024;
        end
        else if (cfg_wr)
        begin
            case (cfg_sel)
                REG_SILENCE_LEVEL:    silence_level_reg <= $signed(pwdata[15:0]);
                REG_PITCH_MIN:        pitch_min_reg     <= pwdata[17:0];
                REG_PITCH_MAX:        pitch_max_reg     <= pwdata[17:0];
                REG_MIN_CONFIDENCE:   min_conf_reg      <= pwdata[16:0];
                REG_MIN_NOTE_SAMPLES: min_note_reg      <= pwdata[19:0];
                REG_ONSET_COMP:       onset_comp_reg    <= pwdata[15:0];
                REG_MIN_SPLIT:        min_split_reg     <= pwdata[7:0];
                REG_ONSET_SETTLE:     settle_reg        <= pwdata[15:0];
                default:              ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            REG_SILENCE_LEVEL:    prdata = 32'($unsigned(silence_level_reg));
            REG_PITCH_MIN:        prdata = 32'(pitch_min_reg);
            REG_PITCH_MAX:        prdata = 32'(pitch_max_reg);
            REG_MIN_CONFIDENCE:   prdata = 32'(min_conf_reg);
            REG_MIN_NOTE_SAMPLES: prdata = 32'(min_note_reg);
            REG_ONSET_COMP:       prdata = 32'(onset_comp_reg);
            REG_MIN_SPLIT:        prdata = 32'(min_split_reg);
            REG_ONSET_SETTLE:     prdata = 32'(settle_reg);
            default:              prdata = 32'd0;
        endcase
    end

    // sequencer state
    ans_state_t state_reg, state_next;

    // captured frame item
    logic               onset_reg, onset_next;
    logic [31:0]        osamp_reg, osamp_next;
    logic signed [15:0] level_reg, level_next;
    logic [17:0]        pitch_reg, pitch_next;
    logic [16:0]        conf_reg, conf_next;
    logic               eos_reg, eos_next;
    logic [31:0]        final_reg, final_next;

    // per-frame derived values
    logic [16:0] w_reg, w_next;
    logic [34:0] prod_reg, prod_next;
    logic        has_pitch_reg, has_pitch_next;
    logic        silent_reg, silent_next;
    logic [31:0] onset_pos_reg, onset_pos_next;
    logic [31:0] frame_reg, frame_next;
    logic        jump_bit_reg, jump_bit_next;

    // note state
    logic        in_note_reg, in_note_next;
    logic        supp_reg, supp_next;
    logic [31:0] note_start_reg, note_start_next;
    logic [1:0]  silent_run_reg, silent_run_next;
    logic [1:0]  jump_run_reg, jump_run_next;
    logic [7:0]  since_split_reg, since_split_next;
    logic [55:0] wps_reg, wps_next;
    logic [39:0] ws_reg, ws_next;
    logic [39:0] ct_reg, ct_next;
    logic [23:0] pf_reg, pf_next;
    logic [31:0] frame_pos_reg, frame_pos_next;

    // flush context
    logic [31:0] end_reg, end_next;
    logic        post_start_reg, post_start_next;
    logic        post_supp_reg, post_supp_next;
    logic [31:0] post_at_reg, post_at_next;
    logic        log_midi_reg, log_midi_next;
    logic [1:0]  log_idx_reg, log_idx_next;
    logic        div_conf_reg, div_conf_next;
    logic [ANS_LOG_RW-1:0] lw_reg, lw_next;
    logic [ANS_LOG_RW-1:0] lv_reg, lv_next;
    logic [ANS_LOG_RW-1:0] lx_reg, lx_next;
    logic [17:0] mp_reg, mp_next;
    logic [7:0]  midi_reg, midi_next;
    logic [16:0] mc_reg, mc_next;

    // output item register
    logic        out_valid_reg, out_valid_next;
    logic [31:0] out_start_reg, out_start_next;
    logic [31:0] out_end_reg, out_end_next;
    logic [17:0] out_mp_reg, out_mp_next;
    logic [7:0]  out_midi_reg, out_midi_next;
    logic [16:0] out_mc_reg, out_mc_next;

    // shared units
    ans_log_req_t          log_req;
    logic                  log_done;
    logic [ANS_LOG_RW-1:0] log_result;
    ans_div_req_t          div_req;
    logic                  div_done;
    logic [ANS_DIV_DW-1:0] div_q;

    ans_log2 u_log2 (
        .clk    (clk),
        .rst_n  (rst_n),
        .req    (log_req),
        .done   (log_done),
        .result (log_result)
    );

    ans_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .req      (div_req),
        .done     (div_done),
        .quotient (div_q)
    );

    // decoded conditions shared by the next-state and datapath blocks
    logic               in_acc;
    logic               out_free;
    logic [16:0]        minconf;
    logic               elig;
    logic               need_log;
    logic               direct_jump;
    logic [1:0]         sr_inc;
    logic [1:0]         jr_new;
    logic               onset_split;
    logic               do_split;
    logic               len_ok;
    logic               pitched_note;
    logic               last_log;
    logic signed [32:0] len_diff;
    logic signed [32:0] settle_diff;
    logic [23:0]        pf1;

    assign in_acc   = frame.valid && frame.ready;
    assign out_free = !out_valid_reg || note.ready;
    assign minconf  = (min_conf_reg > ANS_FULL_CONF) ? ANS_FULL_CONF : min_conf_reg;
    assign elig     = has_pitch_reg && (conf_reg >= minconf) && (ws_reg != 40'd0);
    assign need_log = elig && (pitch_reg != 18'd0) && (wps_reg != 56'd0);
    assign direct_jump = elig && ((pitch_reg == 18'd0) != (wps_reg == 56'd0));
    assign sr_inc   = (silent_run_reg == 2'd3) ? 2'd3 : silent_run_reg + 2'd1;
    // jump run only grows on eligible jumping frames
    assign jr_new   = (elig && jump_bit_reg) ?
                      ((jump_run_reg == 2'd3) ? 2'd3 : jump_run_reg + 2'd1) : 2'd0;
    assign settle_diff = $signed({1'b0, onset_pos_reg}) - $signed({1'b0, note_start_reg});
    // delayed onsets split only once the settle window has passed
    assign onset_split = onset_reg &&
                         (!supp_reg || settle_diff >= $signed({17'd0, settle_reg}));
    assign do_split = (since_split_reg >= min_split_reg) &&
                      (onset_split || jr_new >= 2'd2);
    assign len_diff = $signed({1'b0, end_reg}) - $signed({1'b0, note_start_reg});
    assign len_ok   = len_diff >= $signed({13'd0, min_note_reg});
    assign pitched_note = (ws_reg != 40'd0) && (wps_reg != 56'd0);
    assign last_log = (log_idx_reg == 2'd2);
    assign pf1      = (pf_reg == 24'd0) ? 24'd1 : pf_reg;

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    state_next = ST_PREP;
                end
            end
            ST_PREP: state_next = ST_EVAL;
            ST_EVAL:
            begin
                if (eos_reg)
                begin
                    state_next = in_note_reg ? ST_FLUSH : ST_IDLE;
                end
                else if (!in_note_reg)
                begin
                    state_next = ST_IDLE;
                end
                else if (silent_reg)
                begin
                    state_next = (sr_inc >= 2'd2) ? ST_FLUSH : ST_IDLE;
                end
                else
                begin
                    state_next = need_log ? ST_LOG_GO : ST_DECIDE;
                end
            end
            ST_LOG_GO: state_next = ST_LOG_WAIT;
            ST_LOG_WAIT:
            begin
                if (log_done)
                begin
                    if (!last_log)
                    begin
                        state_next = ST_LOG_GO;
                    end
                    else
                    begin
                        state_next = log_midi_reg ? ST_MIDI : ST_JCALC;
                    end
                end
            end
            ST_JCALC:  state_next = ST_DECIDE;
            ST_DECIDE: state_next = do_split ? ST_FLUSH : ST_IDLE;
            ST_FLUSH:  state_next = len_ok ? ST_DIV_GO : ST_POST;
            ST_DIV_GO: state_next = ST_DIV_WAIT;
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    state_next = div_conf_reg ? ST_OUT : ST_LOG_GO;
                end
            end
            ST_MIDI: state_next = ST_DIV_GO;
            ST_OUT:
            begin
                if (out_free)
                begin
                    state_next = ST_POST;
                end
            end
            ST_POST: state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    // datapath
    logic [16:0]        w_c;
    logic [32:0]        win_hi;
    logic               det_ok;
    logic [32:0]        comp_s;
    logic [56:0]        wps_sum;
    logic [40:0]        ws_sum;
    logic [40:0]        ct_sum;
    logic signed [23:0] jd;
    logic [23:0]        jd_abs;
    logic [27:0]        jd_x10;
    logic signed [23:0] md;
    logic signed [28:0] mv;
    logic [28:0]        mv_r;
    logic [31:0]        split_at;
    logic [16:0]        conf_c;

    always_comb
    begin
        conf_c  = (frame.pitch_confidence > ANS_FULL_CONF) ? ANS_FULL_CONF
                                                           : frame.pitch_confidence;
        w_c     = (conf_reg > ANS_MIN_WEIGHT) ? conf_reg : ANS_MIN_WEIGHT;
        win_hi  = {1'b0, frame_pos_reg} + 33'(HOP_SAMPLES);
        det_ok  = onset_reg && !osamp_reg[31] && ({1'b0, osamp_reg} <= win_hi);
        comp_s  = {1'b0, osamp_reg} - {17'd0, onset_comp_reg};
        wps_sum = {1'b0, wps_reg} + 57'(prod_reg);
        ws_sum  = {1'b0, ws_reg} + 41'(w_reg);
        ct_sum  = {1'b0, ct_reg} + 41'(conf_reg);
        jd      = $signed({2'b0, lx_reg}) -
                  ($signed({2'b0, lw_reg}) - $signed({2'b0, lv_reg}));
        jd_abs  = jd[23] ? 24'(-jd) : 24'(jd);
        jd_x10  = 28'(jd_abs) * 28'd10;
        // 69 + 12 * (log2 mean - log2 reference) in q16
        md      = $signed({2'b0, lw_reg}) - $signed({2'b0, lv_reg}) -
                  $signed({2'b0, lx_reg});
        mv      = $signed(29'(4521984)) + 29'(md) * 29'sd12;
        mv_r    = $unsigned(mv) + 29'd32768;
        split_at = onset_split ? onset_pos_reg : frame_reg;

        onset_next       = onset_reg;
        osamp_next       = osamp_reg;
        level_next       = level_reg;
        pitch_next       = pitch_reg;
        conf_next        = conf_reg;
        eos_next         = eos_reg;
        final_next       = final_reg;
        w_next           = w_reg;
        prod_next        = prod_reg;
        has_pitch_next   = has_pitch_reg;
        silent_next      = silent_reg;
        onset_pos_next   = onset_pos_reg;
        frame_next       = frame_reg;
        jump_bit_next    = jump_bit_reg;
        in_note_next     = in_note_reg;
        supp_next        = supp_reg;
        note_start_next  = note_start_reg;
        silent_run_next  = silent_run_reg;
        jump_run_next    = jump_run_reg;
        since_split_next = since_split_reg;
        wps_next         = wps_reg;
        ws_next          = ws_reg;
        ct_next          = ct_reg;
        pf_next          = pf_reg;
        frame_pos_next   = frame_pos_reg;
        end_next         = end_reg;
        post_start_next  = post_start_reg;
        post_supp_next   = post_supp_reg;
        post_at_next     = post_at_reg;
        log_midi_next    = log_midi_reg;
        log_idx_next     = log_idx_reg;
        div_conf_next    = div_conf_reg;
        lw_next          = lw_reg;
        lv_next          = lv_reg;
        lx_next          = lx_reg;
        mp_next          = mp_reg;
        midi_next        = midi_reg;
        mc_next          = mc_reg;
        out_valid_next   = out_valid_reg;
        out_start_next   = out_start_reg;
        out_end_next     = out_end_reg;
        out_mp_next      = out_mp_reg;
        out_midi_next    = out_midi_reg;
        out_mc_next      = out_mc_reg;
        log_req.start    = 1'b0;
        log_req.operand  = wps_reg;
        div_req.start    = 1'b0;
        div_req.dividend = 57'(wps_reg) + 57'(ws_reg >> 1);
        div_req.divisor  = ws_reg;

        if (out_valid_reg && note.ready)
        begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE:
            begin
                if (in_acc)
                begin
                    onset_next = frame.onset_flag;
                    osamp_next = frame.onset_sample;
                    level_next = $signed(frame.level_db);
                    pitch_next = frame.pitch_hz;
                    conf_next  = conf_c;
                    eos_next   = frame.end_of_stream;
                    final_next = frame.final_sample;
                end
            end
            ST_PREP:
            begin
                w_next         = w_c;
                prod_next      = 35'(pitch_reg) * 35'(w_c);
                has_pitch_next = (pitch_reg >= pitch_min_reg) && (pitch_reg <= pitch_max_reg);
                // the non-finite code is the most negative level, always silent
                silent_next    = level_reg <= silence_level_reg;
                frame_next     = frame_pos_reg;
                if (det_ok)
                begin
                    onset_pos_next = comp_s[32] ? 32'd0 : comp_s[31:0];
                end
                else
                begin
                    onset_pos_next = frame_pos_reg;
                end
            end
            ST_EVAL:
            begin
                if (eos_reg)
                begin
                    frame_pos_next  = 32'd0;
                    end_next        = final_reg;
                    post_start_next = 1'b0;
                end
                else
                begin
                    frame_pos_next = frame_reg + 32'(HOP_SAMPLES);
                    if (!in_note_reg)
                    begin
                        if (onset_reg || !silent_reg)
                        begin
                            in_note_next     = 1'b1;
                            supp_next        = !onset_reg;
                            note_start_next  = onset_pos_reg;
                            silent_run_next  = 2'd0;
                            jump_run_next    = 2'd0;
                            since_split_next = 8'd0;
                            wps_next = has_pitch_reg ? 56'(prod_reg) : 56'd0;
                            ws_next  = has_pitch_reg ? 40'(w_reg) : 40'd0;
                            ct_next  = has_pitch_reg ? 40'(conf_reg) : 40'd0;
                            pf_next  = has_pitch_reg ? 24'd1 : 24'd0;
                        end
                    end
                    else
                    begin
                        if (since_split_reg != 8'hFF)
                        begin
                            since_split_next = since_split_reg + 8'd1;
                        end
                        if (silent_reg)
                        begin
                            silent_run_next = sr_inc;
                            end_next        = frame_reg;
                            post_start_next = 1'b0;
                        end
                        else
                        begin
                            silent_run_next = 2'd0;
                            jump_bit_next   = direct_jump;
                            log_midi_next   = 1'b0;
                            log_idx_next    = 2'd0;
                        end
                    end
                end
            end
            ST_LOG_GO:
            begin
                log_req.start = 1'b1;
                case (log_idx_reg)
                    2'd0:    log_req.operand = wps_reg;
                    2'd1:    log_req.operand = 56'(ws_reg);
                    default: log_req.operand = log_midi_reg ? ANS_REF_PITCH
                                                            : 56'(pitch_reg);
                endcase
            end
            ST_LOG_WAIT:
            begin
                if (log_done)
                begin
                    case (log_idx_reg)
                        2'd0:    lw_next = log_result;
                        2'd1:    lv_next = log_result;
                        default: lx_next = log_result;
                    endcase
                    log_idx_next = log_idx_reg + 2'd1;
                end
            end
            ST_JCALC:
            begin
                // a jump is 1.2 semitones or more, tenfold log2 distance of one
                jump_bit_next = jd_x10 >= 28'd65536;
            end
            ST_DECIDE:
            begin
                jump_run_next = jr_new;
                if (do_split)
                begin
                    end_next        = split_at;
                    post_start_next = 1'b1;
                    post_supp_next  = !onset_split;
                    post_at_next    = split_at;
                end
                else if (has_pitch_reg)
                begin
                    wps_next = wps_sum[56] ? {56{1'b1}} : wps_sum[55:0];
                    ws_next  = ws_sum[40] ? {40{1'b1}} : ws_sum[39:0];
                    ct_next  = ct_sum[40] ? {40{1'b1}} : ct_sum[39:0];
                    if (pf_reg != {24{1'b1}})
                    begin
                        pf_next = pf_reg + 24'd1;
                    end
                end
            end
            ST_FLUSH:
            begin
                if (pitched_note)
                begin
                    div_conf_next = 1'b0;
                end
                else
                begin
                    mp_next       = 18'd0;
                    midi_next     = 8'hFF;
                    div_conf_next = 1'b1;
                end
            end
            ST_DIV_GO:
            begin
                div_req.start = 1'b1;
                if (div_conf_reg)
                begin
                    div_req.dividend = 57'(ct_reg) + 57'(pf1 >> 1);
                    div_req.divisor  = 40'(pf1);
                end
            end
            ST_DIV_WAIT:
            begin
                if (div_done)
                begin
                    if (div_conf_reg)
                    begin
                        mc_next = (div_q > 57'(ANS_FULL_CONF)) ? ANS_FULL_CONF
                                                               : div_q[16:0];
                    end
                    else
                    begin
                        mp_next       = (div_q > 57'd262143) ? 18'd262143 : div_q[17:0];
                        log_midi_next = 1'b1;
                        log_idx_next  = 2'd0;
                    end
                end
            end
            ST_MIDI:
            begin
                // negative values round to zero or below and clamp to zero
                if (mv[28])
                begin
                    midi_next = 8'd0;
                end
                else if (mv_r[28:16] > 13'd127)
                begin
                    midi_next = 8'd127;
                end
                else
                begin
                    midi_next = mv_r[23:16];
                end
                div_conf_next = 1'b1;
            end
            ST_OUT:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    out_start_next = note_start_reg;
                    out_end_next   = end_reg;
                    out_mp_next    = mp_reg;
                    out_midi_next  = midi_reg;
                    out_mc_next    = mc_reg;
                end
            end
            ST_POST:
            begin
                in_note_next     = post_start_reg;
                supp_next        = post_start_reg && post_supp_reg;
                note_start_next  = post_start_reg ? post_at_reg : 32'd0;
                silent_run_next  = 2'd0;
                jump_run_next    = 2'd0;
                since_split_next = post_start_reg ? 8'd0 : 8'hFF;
                if (post_start_reg && has_pitch_reg)
                begin
                    wps_next = 56'(prod_reg);
                    ws_next  = 40'(w_reg);
                    ct_next  = 40'(conf_reg);
                    pf_next  = 24'd1;
                end
                else
                begin
                    wps_next = 56'd0;
                    ws_next  = 40'd0;
                    ct_next  = 40'd0;
                    pf_next  = 24'd0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= ST_IDLE;
            in_note_reg     <= 1'b0;
            supp_reg        <= 1'b0;
            note_start_reg  <= 32'd0;
            silent_run_reg  <= 2'd0;
            jump_run_reg    <= 2'd0;
            since_split_reg <= 8'hFF;
            wps_reg         <= 56'd0;
            ws_reg          <= 40'd0;
            ct_reg          <= 40'd0;
            pf_reg          <= 24'd0;
            frame_pos_reg   <= 32'd0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            state_reg       <= state_next;
            in_note_reg     <= in_note_next;
            supp_reg        <= supp_next;
            note_start_reg  <= note_start_next;
            silent_run_reg  <= silent_run_next;
            jump_run_reg    <= jump_run_next;
            since_split_reg <= since_split_next;
            wps_reg         <= wps_next;
            ws_reg          <= ws_next;
            ct_reg          <= ct_next;
            pf_reg          <= pf_next;
            frame_pos_reg   <= frame_pos_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        onset_reg      <= onset_next;
        osamp_reg      <= osamp_next;
        level_reg      <= level_next;
        pitch_reg      <= pitch_next;
        conf_reg       <= conf_next;
        eos_reg        <= eos_next;
        final_reg      <= final_next;
        w_reg          <= w_next;
        prod_reg       <= prod_next;
        has_pitch_reg  <= has_pitch_next;
        silent_reg     <= silent_next;
        onset_pos_reg  <= onset_pos_next;
        frame_reg      <= frame_next;
        jump_bit_reg   <= jump_bit_next;
        end_reg        <= end_next;
        post_start_reg <= post_start_next;
        post_supp_reg  <= post_supp_next;
        post_at_reg    <= post_at_next;
        log_midi_reg   <= log_midi_next;
        log_idx_reg    <= log_idx_next;
        div_conf_reg   <= div_conf_next;
        lw_reg         <= lw_next;
        lv_reg         <= lv_next;
        lx_reg         <= lx_next;
        mp_reg         <= mp_next;
        midi_reg       <= midi_next;
        mc_reg         <= mc_next;
        out_start_reg  <= out_start_next;
        out_end_reg    <= out_end_next;
        out_mp_reg     <= out_mp_next;
        out_midi_reg   <= out_midi_next;
        out_mc_reg     <= out_mc_next;
    end

    // ports
    assign frame.ready          = (state_reg == ST_IDLE);
    assign note.valid           = out_valid_reg;
    assign note.start_sample    = out_start_reg;
    assign note.end_sample      = out_end_reg;
    assign note.mean_pitch      = out_mp_reg;
    assign note.midi_note       = out_midi_reg;
    assign note.mean_confidence = out_mc_reg;
endmodule

// ===== design/ans_checker.sv =====
// port-level checks of the note segmenter, bound to the top level
// depends on assert_macros.svh and audio_note_segmenter
`include "assert_macros.svh"

module ans_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        in_valid,
    input logic        in_ready,
    input logic        out_valid,
    input logic        out_ready,
    input logic [31:0] out_start
);
    // a waiting note item holds
    `ASN_ASSERT_NEXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_start))
    // a frame keeps the block busy on the next cycle
    `ASN_ASSERT_NEXT(a_busy_after_accept, clk, rst_n, in_valid && in_ready, !in_ready)
    // a new note item is only produced while a frame is at work
    `ASN_ASSERT_IMPL(a_note_while_busy, clk, rst_n, $rose(out_valid), !in_ready)
endmodule

bind audio_note_segmenter ans_checker u_ans_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (frame.valid),
    .in_ready  (frame.ready),
    .out_valid (note.valid),
    .out_ready (note.ready),
    .out_start (note.start_sample)
);
